FILE: design/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Used by uer_ctrl, uer_dpath and the top level; depends on nothing.
`timescale 1ns / 1ps

package uer_pkg;

   // Configuration port geometry
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERIODIC_ENABLE  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERIOD_TICKS     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD_INCHES = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICKS_PER_INCH   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT_TICKS    = 3'd4;

   // Configuration reset values
   localparam logic [15:0] PERIOD_TICKS_RST     = 16'd65535;
   localparam logic [14:0] THRESHOLD_INCHES_RST = 15'd24;
   localparam logic [7:0]  TICKS_PER_INCH_RST   = 8'd74;
   localparam logic [15:0] TIMEOUT_TICKS_RST    = 16'd10000;

   // Field widths fixed by the interface
   localparam int DIST_BITS = 15;
   localparam int TRIG_BITS = 4;
   localparam int TPI_BITS  = 8;
   localparam logic [DIST_BITS-1:0] DIST_MAX = 15'd32767;

   // Controller to datapath commands
   typedef struct packed {
      logic step;       // item accepted this cycle
      logic div_step;   // one divider iteration
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_div;   // accepted item ends with an echo fall
      logic div_last;   // current divider iteration is the final one
   } status_type;

endpackage

FILE: design/uer_ctrl.sv
// Handshake controller for the ultrasonic echo ranger.
// Sequences accept, serial divide and result hand-off; uses uer_pkg types.
`timescale 1ns / 1ps

module uer_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  uer_pkg::status_type status,
   output uer_pkg::cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign accept       = req_valid & ~req_stall_ff;
   assign cmd.step     = accept;
   assign cmd.div_step = (state_ff == ST_DIV);
   assign req_stall    = req_stall_ff;
   assign rsp_valid    = rsp_valid_ff;

   // State and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  req_stall_ff <= 1'b1;
                  if (status.need_div) begin
                     state_ff <= ST_DIV;
                  end else begin
                     state_ff     <= ST_OUT;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            ST_DIV: begin
               if (status.div_last) begin
                  state_ff     <= ST_OUT;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_stall_ff <= 1'b0;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

FILE: design/uer_dpath.sv
// Datapath of the ultrasonic echo ranger: config registers, tick counters,
// echo edge logic, serial restoring divider and result registers. Uses uer_pkg.
`timescale 1ns / 1ps

module uer_dpath #(
   parameter int TRIGGER_TICKS = 5,
   parameter int COUNT_BITS    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  uer_pkg::cmd_type                     cmd,
   output uer_pkg::status_type                  status,
   input  logic                                 csr_we,
   input  logic [uer_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                 req_echo_level,
   input  logic                                 req_clear_flag,
   output logic                                 rsp_trigger_out,
   output logic                                 rsp_measure_done,
   output logic                                 rsp_timed_out,
   output logic [uer_pkg::DIST_BITS-1:0]        rsp_distance_inches,
   output logic                                 rsp_obstacle_flag,
   output logic                                 rsp_stop_motion
);

   localparam int CW   = COUNT_BITS;
   localparam int WW   = (CW > 16) ? CW : 16;             // compare width
   localparam int QW   = (CW > uer_pkg::DIST_BITS) ? CW : uer_pkg::DIST_BITS;
   localparam int DVW  = uer_pkg::TPI_BITS + 1;           // 2 * ticks_per_inch
   localparam int CNTW = (CW > 1) ? $clog2(CW) : 1;
   localparam int TB   = uer_pkg::TRIG_BITS;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_TRIG = 2'd1;
   localparam logic [1:0] PH_RISE = 2'd2;
   localparam logic [1:0] PH_FALL = 2'd3;

   function automatic logic [CW-1:0] count_up(input logic [CW-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // Configuration registers
   logic        periodic_enable_ff;
   logic [15:0] period_ticks_ff;
   logic [14:0] threshold_inches_ff;
   logic [7:0]  ticks_per_inch_ff;
   logic [15:0] timeout_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         periodic_enable_ff  <= 1'b0;
         period_ticks_ff     <= uer_pkg::PERIOD_TICKS_RST;
         threshold_inches_ff <= uer_pkg::THRESHOLD_INCHES_RST;
         ticks_per_inch_ff   <= uer_pkg::TICKS_PER_INCH_RST;
         timeout_ticks_ff    <= uer_pkg::TIMEOUT_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            uer_pkg::CSR_PERIODIC_ENABLE:  periodic_enable_ff  <= csr_wdata[0];
            uer_pkg::CSR_PERIOD_TICKS:     period_ticks_ff     <= csr_wdata;
            uer_pkg::CSR_THRESHOLD_INCHES: threshold_inches_ff <= csr_wdata[14:0];
            uer_pkg::CSR_TICKS_PER_INCH:   ticks_per_inch_ff   <= csr_wdata[7:0];
            uer_pkg::CSR_TIMEOUT_TICKS:    timeout_ticks_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Ranger state
   logic [1:0]    phase_ff, phase_in;
   logic [CW-1:0] period_count_ff, period_count_in;
   logic [TB-1:0] trigger_count_ff, trigger_count_in;
   logic [CW-1:0] timeout_count_ff, timeout_count_in;
   logic [CW-1:0] echo_width_ff, echo_width_in;
   logic          echo_prev_ff;
   logic          flag_store_ff, flag_store_in;
   logic [uer_pkg::DIST_BITS-1:0] last_distance_ff, last_distance_in;

   // Result registers
   logic trigger_ff, trigger_in;
   logic done_ff, done_in;
   logic tmo_ff, tmo_in;
   logic stop_ff, stop_in;

   // Divider registers
   logic [CW-1:0]   div_num_ff, div_num_in;
   logic [DVW-1:0]  div_rem_ff, div_rem_in;
   logic [CNTW-1:0] div_cnt_ff, div_cnt_in;

   // Per-tick step logic
   logic          rise, fall;
   logic [15:0]   period_eff;
   logic [CW-1:0] pc_up, to_up;
   logic [TB-1:0] tc_up;
   logic          step_done, step_tmo, step_trig, step_div;

   assign rise       = req_echo_level & ~echo_prev_ff;
   assign fall       = ~req_echo_level & echo_prev_ff;
   assign period_eff = (period_ticks_ff == 16'd0) ? 16'd1 : period_ticks_ff;
   assign pc_up      = count_up(period_count_ff);
   assign to_up      = count_up(timeout_count_ff);
   assign tc_up      = trigger_count_ff + 1'b1;

   always_comb begin
      phase_in         = phase_ff;
      period_count_in  = period_count_ff;
      trigger_count_in = trigger_count_ff;
      timeout_count_in = timeout_count_ff;
      echo_width_in    = echo_width_ff;
      step_done        = 1'b0;
      step_tmo         = 1'b0;
      step_trig        = 1'b0;
      step_div         = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (periodic_enable_ff) begin
               if (WW'(pc_up) >= WW'(period_eff)) begin
                  period_count_in  = '0;
                  trigger_count_in = '0;
                  phase_in         = PH_TRIG;
               end else begin
                  period_count_in = pc_up;
               end
            end else begin
               period_count_in = '0;
            end
         end
         PH_TRIG: begin
            step_trig = 1'b1;
            if (tc_up >= TB'(TRIGGER_TICKS)) begin
               trigger_count_in = '0;
               timeout_count_in = '0;
               echo_width_in    = '0;
               phase_in         = PH_RISE;
            end else begin
               trigger_count_in = tc_up;
            end
         end
         PH_RISE: begin
            if (rise) begin
               echo_width_in = '0;
               phase_in      = PH_FALL;
            end else begin
               timeout_count_in = to_up;
               if (WW'(to_up) >= WW'(timeout_ticks_ff)) begin
                  step_done = 1'b1;
                  step_tmo  = 1'b1;
               end
            end
         end
         default: begin
            echo_width_in = count_up(echo_width_ff);
            if (fall) begin
               step_done = 1'b1;
               step_div  = 1'b1;
            end else begin
               timeout_count_in = to_up;
               if (WW'(to_up) >= WW'(timeout_ticks_ff)) begin
                  step_done = 1'b1;
                  step_tmo  = 1'b1;
               end
            end
         end
      endcase
      // End of measurement returns to the period wait
      if (step_done) begin
         phase_in         = PH_IDLE;
         period_count_in  = '0;
         timeout_count_in = '0;
      end
   end

   // One restoring divide iteration
   logic [DVW-1:0] divisor;
   logic [DVW:0]   div_shift;
   logic           div_ge;
   logic [QW-1:0]  quot_ext;
   logic [uer_pkg::DIST_BITS-1:0] dist_sat;

   assign divisor   = {ticks_per_inch_ff, 1'b0};
   assign div_shift = {div_rem_ff, div_num_ff[CW-1]};
   assign div_ge    = div_shift >= {1'b0, divisor};
   assign quot_ext  = QW'({div_num_ff[CW-2:0], div_ge});

   always_comb begin
      if (ticks_per_inch_ff == '0 || quot_ext > QW'(uer_pkg::DIST_MAX)) begin
         dist_sat = uer_pkg::DIST_MAX;
      end else begin
         dist_sat = quot_ext[uer_pkg::DIST_BITS-1:0];
      end
   end

   assign status.need_div = step_div;
   assign status.div_last = (div_cnt_ff == CNTW'(CW - 1));

   // Next values for registers written on step or divide
   always_comb begin
      div_num_in       = div_num_ff;
      div_rem_in       = div_rem_ff;
      div_cnt_in       = div_cnt_ff;
      flag_store_in    = flag_store_ff;
      last_distance_in = last_distance_ff;
      trigger_in       = trigger_ff;
      done_in          = done_ff;
      tmo_in           = tmo_ff;
      stop_in          = stop_ff;
      if (cmd.step) begin
         // clear acts before any detection of this tick
         flag_store_in = req_clear_flag ? 1'b0 : flag_store_ff;
         trigger_in    = step_trig;
         done_in       = step_done;
         tmo_in        = step_tmo;
         stop_in       = 1'b0;
         div_num_in    = echo_width_in;
         div_rem_in    = '0;
         div_cnt_in    = '0;
      end else if (cmd.div_step) begin
         div_num_in = {div_num_ff[CW-2:0], div_ge};
         div_rem_in = div_ge ? DVW'(div_shift - {1'b0, divisor}) : DVW'(div_shift);
         div_cnt_in = div_cnt_ff + 1'b1;
         if (status.div_last) begin
            last_distance_in = dist_sat;
            if (dist_sat <= threshold_inches_ff) begin
               flag_store_in = 1'b1;
               stop_in       = 1'b1;
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         period_count_ff  <= '0;
         trigger_count_ff <= '0;
         timeout_count_ff <= '0;
         echo_width_ff    <= '0;
         echo_prev_ff     <= 1'b0;
         flag_store_ff    <= 1'b0;
         last_distance_ff <= '0;
         trigger_ff       <= 1'b0;
         done_ff          <= 1'b0;
         tmo_ff           <= 1'b0;
         stop_ff          <= 1'b0;
      end else begin
         if (cmd.step) begin
            phase_ff         <= phase_in;
            period_count_ff  <= period_count_in;
            trigger_count_ff <= trigger_count_in;
            timeout_count_ff <= timeout_count_in;
            echo_width_ff    <= echo_width_in;
            echo_prev_ff     <= req_echo_level;
         end
         flag_store_ff    <= flag_store_in;
         last_distance_ff <= last_distance_in;
         trigger_ff       <= trigger_in;
         done_ff          <= done_in;
         tmo_ff           <= tmo_in;
         stop_ff          <= stop_in;
      end
   end

   // Divider working registers
   always_ff @(posedge clock) begin
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_cnt_ff <= div_cnt_in;
   end

   assign rsp_trigger_out     = trigger_ff;
   assign rsp_measure_done    = done_ff;
   assign rsp_timed_out       = tmo_ff;
   assign rsp_distance_inches = last_distance_ff;
   assign rsp_obstacle_flag   = flag_store_ff;
   assign rsp_stop_motion     = stop_ff;

endmodule

FILE: design/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger: one timer tick item in, one status item out.
// The result valid is registered and rises in the cycle after accept; a tick
// that sees the echo fall first runs the divider, one quotient bit per cycle.
// Requests stall from accept until the result is taken, so one item at a time.
// Synchronous active-high reset returns config, control and result registers to defaults, ranger idle.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger #(
   parameter int TRIGGER_TICKS = 5,
   parameter int COUNT_BITS    = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_echo_level,
   input  logic                                req_clear_flag,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_trigger_out,
   output logic                                rsp_measure_done,
   output logic                                rsp_timed_out,
   output logic [uer_pkg::DIST_BITS-1:0]       rsp_distance_inches,
   output logic                                rsp_obstacle_flag,
   output logic                                rsp_stop_motion,
   input  logic                                csr_we,
   input  logic [uer_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   uer_pkg::cmd_type    cmd;
   uer_pkg::status_type status;

   // Sequencer
   uer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Counters, divider and result registers
   uer_dpath #(
      .TRIGGER_TICKS (TRIGGER_TICKS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_echo_level      (req_echo_level),
      .req_clear_flag      (req_clear_flag),
      .rsp_trigger_out     (rsp_trigger_out),
      .rsp_measure_done    (rsp_measure_done),
      .rsp_timed_out       (rsp_timed_out),
      .rsp_distance_inches (rsp_distance_inches),
      .rsp_obstacle_flag   (rsp_obstacle_flag),
      .rsp_stop_motion     (rsp_stop_motion)
   );

endmodule
